// ===== rtl/sha256_byte_stream_hasher_top_assert.svh =====
// Assertion macros used by the SHA-256 hasher checker
`ifndef SHA256_BYTE_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_TOP_ASSERT_SVH

// Same-cycle implication
`define SBH_ASSERT_IMPLY(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error("sbh check failed");

// Next-cycle implication
`define SBH_ASSERT_NEXT(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error("sbh check failed");

`endif

// ===== rtl/sbh_pkg.sv =====
// Types, constants and round functions of the SHA-256 byte stream hasher
package sbh_pkg;

   localparam logic [7:0] PAD_MARK   = 8'h80;
   localparam logic [5:0] LEN_OFFSET = 6'd56;

   localparam logic [31:0] INIT_HASH [0:7] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // One 512-bit block travelling from the front to the compression engine
   typedef struct packed {
      logic [511:0] block;
      logic         final_blk;
   } sbh_blk_type;

   typedef enum logic [1:0] {
      FE_ACCEPT,
      FE_PAD,
      FE_LEN
   } fe_state_type;

   typedef enum logic [1:0] {
      BE_IDLE,
      BE_ROUND,
      BE_FINISH
   } be_state_type;

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
   endfunction

   function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                          input logic [31:0] g);
      return (e & f) ^ (~e & g);
   endfunction

   function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c);
      return (a & b) ^ (a & c) ^ (b & c);
   endfunction

endpackage

// ===== rtl/sbh_front.sv =====
// Byte packer and padding generator: gathers bytes into blocks and emits padded final blocks
module sbh_front (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          req_data_byte,
   input  logic                req_byte_present,
   input  logic                req_end_of_message,
   input  logic                req_push,
   output logic                req_full,
   input  logic                q_full,
   output logic                q_push,
   output sbh_pkg::sbh_blk_type q_data
);

   sbh_pkg::fe_state_type state_ff, state_in;
   logic [60:0]  count_ff, count_in;
   logic [31:0]  blk_ff [16];
   logic         accept;
   logic         blk_we;
   logic [5:0]   fill;
   logic [63:0]  bit_len;
   logic [511:0] flat_blk;
   logic [511:0] cur_blk;
   logic [511:0] pad_blk;
   logic         in_len;

   // Take an item only while packing and the queue has room for a completed block
   assign req_full = (state_ff != sbh_pkg::FE_ACCEPT) || q_full;
   assign accept   = req_push && !req_full;
   assign fill     = count_ff[5:0];
   assign bit_len  = {count_ff, 3'b000};
   assign in_len   = (state_ff == sbh_pkg::FE_LEN);

   // Flatten the buffer; a completing byte lands in the last lane
   always_comb begin
      for (int w = 0; w < 16; w++) begin
         flat_blk[511 - 32 * w -: 32] = blk_ff[w];
      end
      cur_blk = {flat_blk[511:8], req_data_byte};
   end

   // Build the padding block: kept bytes, pad mark, zeros, bit length
   always_comb begin
      logic [7:0] src_byte;
      logic       put_len;
      put_len = in_len || (fill < sbh_pkg::LEN_OFFSET);
      for (int i = 0; i < 64; i++) begin
         src_byte = flat_blk[511 - 8 * i -: 8];
         if (i >= 56 && put_len) begin
            pad_blk[511 - 8 * i -: 8] = bit_len[8 * (63 - i) +: 8];
         end else if (!in_len && (6'(i) < fill)) begin
            pad_blk[511 - 8 * i -: 8] = src_byte;
         end else if (!in_len && (6'(i) == fill)) begin
            pad_blk[511 - 8 * i -: 8] = sbh_pkg::PAD_MARK;
         end else begin
            pad_blk[511 - 8 * i -: 8] = 8'h00;
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sbh_pkg::FE_ACCEPT: begin
            if (accept && req_end_of_message) begin
               state_in = sbh_pkg::FE_PAD;
            end
         end
         sbh_pkg::FE_PAD: begin
            if (!q_full) begin
               state_in = (fill < sbh_pkg::LEN_OFFSET) ? sbh_pkg::FE_ACCEPT : sbh_pkg::FE_LEN;
            end
         end
         sbh_pkg::FE_LEN: begin
            if (!q_full) begin
               state_in = sbh_pkg::FE_ACCEPT;
            end
         end
         default: state_in = sbh_pkg::FE_ACCEPT;
      endcase
   end

   // Outputs: buffer write, count update, block transfer to the queue
   always_comb begin
      q_push            = 1'b0;
      q_data.block      = cur_blk;
      q_data.final_blk  = 1'b0;
      count_in          = count_ff;
      blk_we            = 1'b0;
      unique case (state_ff)
         sbh_pkg::FE_ACCEPT: begin
            if (accept && req_byte_present) begin
               blk_we   = 1'b1;
               count_in = count_ff + 61'd1;
               q_push   = (fill == 6'd63);
            end
         end
         sbh_pkg::FE_PAD: begin
            q_data.block     = pad_blk;
            q_data.final_blk = (fill < sbh_pkg::LEN_OFFSET);
            if (!q_full) begin
               q_push = 1'b1;
               if (fill < sbh_pkg::LEN_OFFSET) begin
                  count_in = '0;
               end
            end
         end
         sbh_pkg::FE_LEN: begin
            q_data.block     = pad_blk;
            q_data.final_blk = 1'b1;
            if (!q_full) begin
               q_push   = 1'b1;
               count_in = '0;
            end
         end
         default: begin
            q_push = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sbh_pkg::FE_ACCEPT;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Byte buffer: write the byte into its lane
   always_ff @(posedge clock) begin
      if (blk_we) begin
         for (int lane = 0; lane < 4; lane++) begin
            if (fill[1:0] == 2'(lane)) begin
               blk_ff[fill[5:2]][8 * (3 - lane) +: 8] <= req_data_byte;
            end
         end
      end
   end

endmodule

// ===== rtl/sbh_queue.sv =====
// Short block queue between the byte packer and the compression engine
module sbh_queue #(
   parameter int DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sbh_pkg::sbh_blk_type push_data,
   output logic                 full,
   input  logic                 pop,
   output sbh_pkg::sbh_blk_type pop_data,
   output logic                 empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sbh_pkg::sbh_blk_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap and track occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the transferred block
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/sbh_back.sv =====
// Compression engine: 64 rounds per block, chaining value and digest output register
module sbh_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   output logic                 q_pop,
   input  sbh_pkg::sbh_blk_type q_data,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output logic [63:0]          rsp_digest_bits_255_192,
   output logic [63:0]          rsp_digest_bits_191_128,
   output logic [63:0]          rsp_digest_bits_127_64,
   output logic [63:0]          rsp_digest_bits_63_0
);

   sbh_pkg::be_state_type state_ff, state_in;
   logic [5:0]   round_ff;
   logic [31:0]  w_ff [16];
   logic [31:0]  v_ff [8];
   logic [31:0]  h_ff [8];
   logic         final_ff;
   logic         out_valid_ff;
   logic [255:0] digest_ff;

   logic         load_blk;
   logic         do_round;
   logic         commit;
   logic         emit;
   logic         slot_free;
   logic [31:0]  t1, t2, w_next;
   logic [31:0]  sum [8];
   logic [255:0] sum_flat;

   assign slot_free = !out_valid_ff || rsp_pop;
   assign rsp_empty = !out_valid_ff;
   assign rsp_digest_bits_255_192 = digest_ff[255:192];
   assign rsp_digest_bits_191_128 = digest_ff[191:128];
   assign rsp_digest_bits_127_64  = digest_ff[127:64];
   assign rsp_digest_bits_63_0    = digest_ff[63:0];

   // One round and one schedule word
   always_comb begin
      t1 = v_ff[7] + sbh_pkg::big_sigma1(v_ff[4]) + sbh_pkg::choose(v_ff[4], v_ff[5], v_ff[6])
         + sbh_pkg::ROUND_K[round_ff] + w_ff[0];
      t2 = sbh_pkg::big_sigma0(v_ff[0]) + sbh_pkg::majority(v_ff[0], v_ff[1], v_ff[2]);
      w_next = sbh_pkg::small_sigma1(w_ff[14]) + w_ff[9] + sbh_pkg::small_sigma0(w_ff[1])
             + w_ff[0];
   end

   // Feed-forward sums
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         sum[i] = h_ff[i] + v_ff[i];
         sum_flat[255 - 32 * i -: 32] = sum[i];
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sbh_pkg::BE_IDLE: begin
            if (!q_empty) begin
               state_in = sbh_pkg::BE_ROUND;
            end
         end
         sbh_pkg::BE_ROUND: begin
            if (round_ff == 6'd63) begin
               state_in = sbh_pkg::BE_FINISH;
            end
         end
         sbh_pkg::BE_FINISH: begin
            if (!final_ff || slot_free) begin
               state_in = sbh_pkg::BE_IDLE;
            end
         end
         default: state_in = sbh_pkg::BE_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      load_blk = 1'b0;
      do_round = 1'b0;
      commit   = 1'b0;
      emit     = 1'b0;
      unique case (state_ff)
         sbh_pkg::BE_IDLE:   load_blk = !q_empty;
         sbh_pkg::BE_ROUND:  do_round = 1'b1;
         sbh_pkg::BE_FINISH: begin
            commit = !final_ff || slot_free;
            emit   = final_ff && slot_free;
         end
         default: load_blk = 1'b0;
      endcase
   end

   assign q_pop = load_blk;

   // Control registers and chaining value
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sbh_pkg::BE_IDLE;
         round_ff     <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= sbh_pkg::INIT_HASH[i];
         end
      end else begin
         state_ff <= state_in;
         if (load_blk) begin
            round_ff <= '0;
         end else if (do_round) begin
            round_ff <= round_ff + 6'd1;
         end
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
         // Fold the block in; restore the initial value after a digest
         if (commit) begin
            for (int i = 0; i < 8; i++) begin
               h_ff[i] <= final_ff ? sbh_pkg::INIT_HASH[i] : sum[i];
            end
         end
      end
   end

   // Working variables, schedule window and digest
   always_ff @(posedge clock) begin
      if (load_blk) begin
         final_ff <= q_data.final_blk;
         for (int i = 0; i < 16; i++) begin
            w_ff[i] <= q_data.block[511 - 32 * i -: 32];
         end
         for (int i = 0; i < 8; i++) begin
            v_ff[i] <= h_ff[i];
         end
      end else if (do_round) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i + 1];
         end
         w_ff[15] <= w_next;
         v_ff[7]  <= v_ff[6];
         v_ff[6]  <= v_ff[5];
         v_ff[5]  <= v_ff[4];
         v_ff[4]  <= v_ff[3] + t1;
         v_ff[3]  <= v_ff[2];
         v_ff[2]  <= v_ff[1];
         v_ff[1]  <= v_ff[0];
         v_ff[0]  <= t1 + t2;
      end
      if (emit) begin
         digest_ff <= sum_flat;
      end
   end

endmodule

// ===== rtl/sha256_byte_stream_hasher_top.sv =====
// Top level of the SHA-256 byte stream hasher
//
// Message bytes enter one per cycle, while req_full is low, through a
// queue-style port; an item with end_of_message set closes the message and
// one 256-bit digest comes out for it. The packer takes one byte per cycle
// while the block queue has room and no padding block is going out; the
// compression engine loads each 64-byte block, runs 64 rounds and adds the
// feed-forward before it takes the next block, with QUEUE_DEPTH blocks of
// slack between the two. The end item makes the packer emit one or two
// padding blocks. The digest waits in an output register, which does not
// stop the front from taking the next message until the block queue fills.
module sha256_byte_stream_hasher_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   input  logic        req_push,
   output logic        req_full,
   output logic [63:0] rsp_digest_bits_255_192,
   output logic [63:0] rsp_digest_bits_191_128,
   output logic [63:0] rsp_digest_bits_127_64,
   output logic [63:0] rsp_digest_bits_63_0,
   output logic        rsp_empty,
   input  logic        rsp_pop
);

   sbh_pkg::sbh_blk_type push_data, pop_data;
   logic q_push, q_full, q_pop, q_empty;

   sbh_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_data_byte      (req_data_byte),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .req_push           (req_push),
      .req_full           (req_full),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_data             (push_data)
   );

   sbh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   sbh_back u_back (
      .clock                   (clock),
      .reset                   (reset),
      .q_empty                 (q_empty),
      .q_pop                   (q_pop),
      .q_data                  (pop_data),
      .rsp_pop                 (rsp_pop),
      .rsp_empty               (rsp_empty),
      .rsp_digest_bits_255_192 (rsp_digest_bits_255_192),
      .rsp_digest_bits_191_128 (rsp_digest_bits_191_128),
      .rsp_digest_bits_127_64  (rsp_digest_bits_127_64),
      .rsp_digest_bits_63_0    (rsp_digest_bits_63_0)
   );

endmodule

// ===== rtl/sbh_checker.sv =====
// Port-level checks of the SHA-256 hasher and their attachment to the top level
`include "sha256_byte_stream_hasher_top_assert.svh"

module sbh_checker (
   input logic        clock,
   input logic        reset,
   input logic [7:0]  req_data_byte,
   input logic        req_byte_present,
   input logic        req_end_of_message,
   input logic        req_push,
   input logic        req_full,
   input logic [63:0] rsp_digest_bits_255_192,
   input logic [63:0] rsp_digest_bits_191_128,
   input logic [63:0] rsp_digest_bits_127_64,
   input logic [63:0] rsp_digest_bits_63_0,
   input logic        rsp_empty,
   input logic        rsp_pop
);

   // A waiting digest holds until its transfer
   `SBH_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_digest_bits_255_192) && $stable(rsp_digest_bits_191_128) && $stable(rsp_digest_bits_127_64) && $stable(rsp_digest_bits_63_0))

   // Reset drops any pending digest
   `SBH_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, rsp_empty)

   // Closing a message stalls the input while padding goes out
   `SBH_ASSERT_NEXT(a_end_stalls, clock, reset, req_push && !req_full && req_end_of_message, req_full)

   // The input port stays usable right after reset
   `SBH_ASSERT_IMPLY(a_ready_after_reset, clock, reset, $past(reset), !req_full)

endmodule

bind sha256_byte_stream_hasher_top sbh_checker u_sbh_checker (.*);

// ===== dv/sha256_byte_stream_hasher_top_test.sv =====
// Self-checking testbench for the SHA-256 byte stream hasher top level
`timescale 1ns / 100ps

module sha256_byte_stream_hasher_top_test;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int ITEM_TARGET  = 1250;
   localparam int MIN_DIGESTS  = 40;
   localparam int BACKUP_HOLD  = 3000;
   localparam int DRAIN_CYCLES = 300;

   localparam logic [31:0] SHA_IV [0:7] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] SHA_ROUND_K [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [7:0]  PAD_BYTE     = 8'h80;
   localparam int          LEN_POSITION = 56;

   typedef struct packed {
      logic [7:0] data;
      logic       present;
      logic       eom;
   } byte_item_type;

   typedef struct packed {
      logic [63:0] bits_255_192;
      logic [63:0] bits_191_128;
      logic [63:0] bits_127_64;
      logic [63:0] bits_63_0;
   } sha_digest_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_byte_present = 1'b0;
   logic        req_end_of_message = 1'b0;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [63:0] rsp_digest_bits_255_192;
   logic [63:0] rsp_digest_bits_191_128;
   logic [63:0] rsp_digest_bits_127_64;
   logic [63:0] rsp_digest_bits_63_0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;

   // Pending input items and the digests they are due to produce
   byte_item_type  byte_feed [$];
   sha_digest_type digests_due [$];

   // Predictor state
   logic [31:0] hash_words [0:7];
   logic [7:0]  block_bytes [0:63];
   logic [60:0] byte_total;

   int stim_total;
   int items_taken;
   int counted_items;
   int message_total;
   int mismatches;
   int cycle_count;
   int hold_left;
   bit hold_used;
   bit took_item;

   sha256_byte_stream_hasher_top dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_data_byte           (req_data_byte),
      .req_byte_present        (req_byte_present),
      .req_end_of_message      (req_end_of_message),
      .req_push                (req_push),
      .req_full                (req_full),
      .rsp_digest_bits_255_192 (rsp_digest_bits_255_192),
      .rsp_digest_bits_191_128 (rsp_digest_bits_191_128),
      .rsp_digest_bits_127_64  (rsp_digest_bits_127_64),
      .rsp_digest_bits_63_0    (rsp_digest_bits_63_0),
      .rsp_empty               (rsp_empty),
      .rsp_pop                 (rsp_pop)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // Run the 64-round compression over the block buffer
   task automatic sha_compress();
      logic [31:0] w [0:63];
      logic [31:0] v [0:7];
      logic [31:0] t1;
      logic [31:0] t2;
      for (int t = 0; t < 16; t++)
         w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
      for (int t = 16; t < 64; t++)
         w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
              + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
      for (int i = 0; i < 8; i++)
         v[i] = hash_words[i];
      for (int t = 0; t < 64; t++) begin
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_ROUND_K[t] + w[t];
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++)
         hash_words[i] = hash_words[i] + v[i];
   endtask

   task automatic restart_hash();
      for (int i = 0; i < 8; i++)
         hash_words[i] = SHA_IV[i];
      byte_total = '0;
   endtask

   // Fold one accepted item into the running hash; queue a digest on message end
   task automatic absorb_item(input byte_item_type it);
      int             fill;
      logic [63:0]    bit_len;
      sha_digest_type dg;
      if (it.present) begin
         block_bytes[byte_total[5:0]] = it.data;
         byte_total = byte_total + 61'd1;
         if (byte_total[5:0] == 6'd0)
            sha_compress();
      end
      if (it.eom) begin
         fill = int'(byte_total[5:0]);
         block_bytes[fill] = PAD_BYTE;
         for (int i = fill + 1; i < 64; i++)
            block_bytes[i] = 8'd0;
         // no room for the length: flush this block and pad a fresh one
         if (fill >= LEN_POSITION) begin
            sha_compress();
            for (int i = 0; i < LEN_POSITION; i++)
               block_bytes[i] = 8'd0;
         end
         bit_len = {byte_total, 3'b000};
         for (int i = 0; i < 8; i++)
            block_bytes[LEN_POSITION + i] = bit_len[63 - 8*i -: 8];
         sha_compress();
         dg.bits_255_192 = {hash_words[0], hash_words[1]};
         dg.bits_191_128 = {hash_words[2], hash_words[3]};
         dg.bits_127_64  = {hash_words[4], hash_words[5]};
         dg.bits_63_0    = {hash_words[6], hash_words[7]};
         digests_due.push_back(dg);
         restart_hash();
      end
   endtask

   task automatic queue_item(input logic [7:0] d, input bit p, input bit e);
      byte_item_type it;
      it.data    = d;
      it.present = p;
      it.eom     = e;
      byte_feed.push_back(it);
      if (p || e)
         counted_items++;
      if (e)
         message_total++;
   endtask

   // Queue a whole message with random bytes and a little noise between them
   task automatic queue_message(input int len);
      bit end_on_byte;
      end_on_byte = 1'b0;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < 4)
            queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         if (i == len - 1 && $urandom_range(0, 1) == 1) begin
            end_on_byte = 1'b1;
            queue_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
         end else begin
            queue_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
         end
      end
      if (!end_on_byte)
         queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   function automatic int pick_length();
      int r;
      int edges [0:9];
      edges = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120};
      r = $urandom_range(0, 99);
      if (r < 8)
         return edges[$urandom_range(0, 9)];
      else if (r < 80)
         return $urandom_range(0, 24);
      return $urandom_range(25, 70);
   endfunction

   // Phase of the run: 0 and 1 swap idle rates, 2 runs flat out
   function automatic int idle_phase();
      if (items_taken * 3 < stim_total)
         return 0;
      else if (items_taken * 3 < stim_total * 2)
         return 1;
      return 2;
   endfunction

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, actual %h", field, want, got);
         mismatches++;
      end
   endtask

   // Build the stimulus, then wait for the last digest and let the block drain
   initial begin
      int special [0:6];
      restart_hash();
      for (int i = 0; i < 64; i++)
         block_bytes[i] = 8'd0;
      counted_items = 0;
      message_total = 0;
      items_taken   = 0;
      mismatches    = 0;
      hold_used     = 1'b0;
      hold_left     = 0;

      // empty message, ignored item, single-byte messages at both byte extremes
      queue_item(8'h5a, 1'b0, 1'b1);
      queue_item(8'hff, 1'b0, 1'b0);
      queue_item(8'h00, 1'b1, 1'b1);
      queue_item(8'hff, 1'b1, 1'b1);
      // "abc" closed by an end item without a byte
      queue_item(8'h61, 1'b1, 1'b0);
      queue_item(8'h62, 1'b1, 1'b0);
      queue_item(8'h63, 1'b1, 1'b0);
      queue_item(8'h00, 1'b0, 1'b1);
      // idle item in the middle of a message, byte and end together
      queue_item(8'h80, 1'b1, 1'b0);
      queue_item(8'h55, 1'b0, 1'b0);
      queue_item(8'h7f, 1'b1, 1'b1);

      // padding boundaries: one block, length spill, byte completing a block
      special = '{0, 1, 55, 56, 63, 64, 65};
      for (int i = 0; i < 7; i++)
         queue_message(special[i]);
      while (counted_items < ITEM_TARGET || message_total < MIN_DIGESTS)
         queue_message(pick_length());
      stim_total = byte_feed.size();

      while (byte_feed.size() != 0 || digests_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && digests_due.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Driver: predict on each transfer, then offer the next item or idle
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         took_item = req_push && !req_full;
         if (took_item) begin
            absorb_item(byte_feed.pop_front());
            items_taken++;
         end
         if (!req_push || took_item) begin
            if (byte_feed.size() != 0 &&
                !(idle_phase() == 0 && $urandom_range(0, 99) < 8) &&
                !(idle_phase() == 1 && $urandom_range(0, 99) < 66)) begin
               req_data_byte      <= byte_feed[0].data;
               req_byte_present   <= byte_feed[0].present;
               req_end_of_message <= byte_feed[0].eom;
               req_push           <= 1'b1;
            end else begin
               req_data_byte      <= 8'($urandom_range(0, 255));
               req_byte_present   <= 1'($urandom_range(0, 1));
               req_end_of_message <= 1'($urandom_range(0, 1));
               req_push           <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each digest transfer against the oldest one due
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (digests_due.size() == 0) begin
               $error("digest transfer with no message pending");
               mismatches++;
            end else begin
               check_field("digest_bits_255_192", digests_due[0].bits_255_192,
                           rsp_digest_bits_255_192);
               check_field("digest_bits_191_128", digests_due[0].bits_191_128,
                           rsp_digest_bits_191_128);
               check_field("digest_bits_127_64", digests_due[0].bits_127_64,
                           rsp_digest_bits_127_64);
               check_field("digest_bits_63_0", digests_due[0].bits_63_0,
                           rsp_digest_bits_63_0);
               void'(digests_due.pop_front());
            end
         end
         // hold off once for a long stretch so the block backs up into req_full
         if (!hold_used && idle_phase() == 2) begin
            hold_used = 1'b1;
            hold_left = BACKUP_HOLD;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (idle_phase() == 0) begin
            rsp_pop <= ($urandom_range(0, 99) >= 66);
         end else if (idle_phase() == 1) begin
            rsp_pop <= ($urandom_range(0, 99) >= 8);
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial cycle_count = 0;

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sbh_pkg.sv
rtl/sbh_front.sv
rtl/sbh_queue.sv
rtl/sbh_back.sv
rtl/sha256_byte_stream_hasher_top.sv
rtl/sbh_checker.sv
dv/sha256_byte_stream_hasher_top_test.sv
